/* rtl/ilb_pkg.sv */
// Shared types and codes for the indexed list buffer.
`default_nettype none
package ilb_pkg;

  // Field widths of the stream beats
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int CNT_W = 5;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  // Compare width for positions against occupancy (position plus one bit)
  localparam int XW    = POS_W + 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic            start;    // capture a new beat
    logic            clamp;    // limit insert position to occupancy
    logic            dir_up;   // shift direction: 1 toward the head (remove)
    logic [ST_W-1:0] st;       // status to report for this beat
    logic            rd;       // read entry at the read pointer, step pointers
    logic            mv;       // write last read entry at the write pointer
    logic            put;      // write the inserted value at the position
    logic            grab;     // keep the last read entry as the result value
    logic            occ_inc;
    logic            occ_dec;
    logic            load_out; // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;       // occupancy reached capacity
    logic pos_ge_occ; // incoming position is at or beyond the end
    logic cnt_zero;   // no entries left to read for the current shift
  } stat_t;

endpackage
`default_nettype wire

/* rtl/ilb_ctrl.sv */
// Controller state machine of the indexed list buffer.
`default_nettype none
module ilb_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [ilb_pkg::OP_W-1:0] in_op,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire ilb_pkg::stat_t        stat,
  output ilb_pkg::cmd_t              cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_GRAB  = 3'd3;
  localparam logic [2:0] S_UP    = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                 state;
  logic [2:0]                 state_next;
  logic [ilb_pkg::OP_W-1:0]   op_r;
  logic                       rd_pend;

  // Decode state into datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          case (in_op)
            ilb_pkg::OP_INSERT: begin
              if (stat.full) begin
                cmd.st     = ilb_pkg::ST_FULL;
                state_next = S_DONE;
              end else begin
                cmd.st     = ilb_pkg::ST_OK;
                cmd.clamp  = 1'b1;
                state_next = S_INS;
              end
            end
            ilb_pkg::OP_REMOVE, ilb_pkg::OP_READ: begin
              cmd.dir_up = 1'b1;
              if (stat.pos_ge_occ) begin
                cmd.st     = ilb_pkg::ST_RANGE;
                state_next = S_DONE;
              end else begin
                cmd.st     = ilb_pkg::ST_OK;
                state_next = S_FETCH;
              end
            end
            default: begin
              cmd.st     = ilb_pkg::ST_RANGE;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_INS: begin
        // shift entries up from the end, then drop the value in
        cmd.rd = !stat.cnt_zero;
        cmd.mv = rd_pend;
        if (stat.cnt_zero && !rd_pend) begin
          cmd.put     = 1'b1;
          cmd.occ_inc = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_FETCH: begin
        cmd.rd     = 1'b1;
        state_next = S_GRAB;
      end
      S_GRAB: begin
        cmd.grab = 1'b1;
        if (op_r == ilb_pkg::OP_READ) begin
          state_next = S_DONE;
        end else begin
          cmd.rd     = !stat.cnt_zero;
          state_next = S_UP;
        end
      end
      S_UP: begin
        // shift entries down toward the removed slot
        cmd.mv = rd_pend;
        cmd.rd = !stat.cnt_zero;
        if (stat.cnt_zero && !rd_pend) begin
          cmd.occ_dec = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state, output valid and the read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= cmd.rd;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Keep the operation of the beat in flight
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r <= in_op;
    end
  end

endmodule
`default_nettype wire

/* rtl/ilb_dp.sv */
// Datapath of the indexed list buffer: entry memory, pointers and result.
`default_nettype none
module ilb_dp #(
  parameter int CAPACITY = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ilb_pkg::cmd_t              cmd,
  output ilb_pkg::stat_t                  stat,
  input  wire logic [ilb_pkg::POS_W-1:0]  in_pos,
  input  wire logic [ilb_pkg::VAL_W-1:0]  in_val,
  output logic [ilb_pkg::ST_W-1:0]        out_status,
  output logic [ilb_pkg::POS_W-1:0]       out_placed,
  output logic [ilb_pkg::VAL_W-1:0]       out_value,
  output logic [ilb_pkg::CNT_W-1:0]       out_count
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ilb_pkg::XW;
  localparam logic [IW-1:0] ONE = IW'(1);

  logic [ilb_pkg::VAL_W-1:0] mem [CAPACITY];
  logic [ilb_pkg::VAL_W-1:0] rdata;
  logic [CW-1:0]             occ;
  logic [CW-1:0]             cnt;
  logic [IW-1:0]             rptr;
  logic [IW-1:0]             wptr;
  logic                      dir_r;
  logic [ilb_pkg::POS_W-1:0] pos_r;
  logic [ilb_pkg::VAL_W-1:0] val_r;
  logic [ilb_pkg::VAL_W-1:0] value_r;
  logic [ilb_pkg::ST_W-1:0]  st_r;

  logic [XW-1:0]             occ_x;
  logic [XW-1:0]             pos_x;
  logic [XW-1:0]             occ_m1;
  logic [XW-1:0]             cnt_init;
  logic [ilb_pkg::POS_W-1:0] pos_eff;
  logic                      pos_gt_occ;
  logic                      wr_en;
  logic [IW-1:0]             waddr;
  logic [ilb_pkg::VAL_W-1:0] wdata;
  logic [XW-1:0]             occ_out_x;

  // Compare the incoming position against occupancy
  always_comb begin
    occ_x           = XW'(occ);
    pos_x           = {1'b0, in_pos};
    occ_m1          = occ_x - XW'(1);
    pos_gt_occ      = pos_x > occ_x;
    stat.full       = occ_x >= XW'(CAPACITY);
    stat.pos_ge_occ = pos_x >= occ_x;
    stat.cnt_zero   = (cnt == '0);
    pos_eff         = (cmd.clamp && pos_gt_occ) ? occ_x[ilb_pkg::POS_W-1:0] : in_pos;
    cnt_init        = occ_x - {1'b0, pos_eff};
  end

  // Select the memory write
  always_comb begin
    wr_en = cmd.mv || cmd.put;
    waddr = cmd.put ? pos_r[IW-1:0] : wptr;
    wdata = cmd.put ? val_r : rdata;
  end

  // Entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[rptr];
    end
  end

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.occ_inc) begin
      occ <= occ + CW'(1);
    end else if (cmd.occ_dec) begin
      occ <= occ - CW'(1);
    end
  end

  // Capture the beat, then step the shift pointers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pos_r   <= pos_eff;
      val_r   <= in_val;
      st_r    <= cmd.st;
      dir_r   <= cmd.dir_up;
      value_r <= '0;
      cnt     <= cnt_init[CW-1:0];
      rptr    <= cmd.dir_up ? in_pos[IW-1:0] : occ_m1[IW-1:0];
    end else begin
      if (cmd.rd) begin
        cnt  <= cnt - CW'(1);
        rptr <= dir_r ? rptr + ONE : rptr - ONE;
        wptr <= dir_r ? rptr - ONE : rptr + ONE;
      end
      if (cmd.grab) begin
        value_r <= rdata;
      end
    end
  end

  // Output register
  assign occ_out_x = XW'(occ);
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= st_r;
      out_placed <= pos_r;
      out_value  <= value_r;
      out_count  <= occ_out_x[ilb_pkg::CNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/indexed_list_buffer.sv */
// Top level of the indexed list buffer: stream ports, controller and datapath.
//
//  channel  | dir | tdata (low bit up)                         | tuser
//  s_axis   | in  | position[7:0], item_value[39:8]            | op[1:0]
//  m_axis   | out | placed_at[7:0], read_value[39:8], count[44:40] | status[1:0]
//
// One beat in flight at a time; one result beat per input beat.
// Insert shifts the entries from the position to the end up by one; remove
// shifts those after the position down by one; read and errors shift none; the
// entry memory, with one read and one write port, moves one entry per cycle.
// Reset clears occupancy and the output valid flag; entries need no clearing.
// A waiting result sits in the output register while the next beat is taken;
// its completion waits until that register is free.
`default_nettype none
module indexed_list_buffer #(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // position[7:0], item_value[39:8]
  input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // placed_at[7:0], read_value[39:8], count[44:40]
  output logic [1:0]       m_axis_tuser   // status[1:0]
);

  ilb_pkg::cmd_t                  cmd;
  ilb_pkg::stat_t                 stat;
  logic [ilb_pkg::ST_W-1:0]       out_status;
  logic [ilb_pkg::POS_W-1:0]      out_placed;
  logic [ilb_pkg::VAL_W-1:0]      out_value;
  logic [ilb_pkg::CNT_W-1:0]      out_count;

  ilb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_op     (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ilb_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_pos     (s_axis_tdata[7:0]),
    .in_val     (s_axis_tdata[39:8]),
    .out_status (out_status),
    .out_placed (out_placed),
    .out_value  (out_value),
    .out_count  (out_count)
  );

  // Pack the result beat
  assign m_axis_tdata = {3'b000, out_count, out_value, out_placed};
  assign m_axis_tuser = out_status;

endmodule
`default_nettype wire

/* rtl/ilb_checker.sv */
// Port-level assertions for the indexed list buffer, bound to the top level.
`default_nettype none
module ilb_checker #(
  parameter int CAPACITY = 16
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // No result beat right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Errors carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ilb_pkg::ST_OK) |-> m_axis_tdata[39:8] == 32'd0)
    else $error("error result with nonzero value");

  // A full report means the list holds capacity entries
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ilb_pkg::ST_FULL)
      |-> m_axis_tdata[44:40] == 5'(CAPACITY % 32))
    else $error("full status with wrong count");

endmodule

bind indexed_list_buffer ilb_checker #(.CAPACITY(CAPACITY)) u_ilb_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

/* tb/indexed_list_buffer_tb.sv */
// Self-checking testbench for the indexed list buffer: directed table, then random ops.
`timescale 1ns / 1ps
module indexed_list_buffer_tb;

  localparam int LIST_CAP     = 16;
  localparam int N_RANDOM     = 400;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int DIR_N        = 25;
  localparam logic [ilb_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [ilb_pkg::ST_W-1:0]  status;
    logic [ilb_pkg::POS_W-1:0] placed;
    logic [ilb_pkg::VAL_W-1:0] value;
    logic [ilb_pkg::CNT_W-1:0] cnt;
  } list_result_t;

  // One directed row; the typed-in result is used only when typed is set
  typedef struct packed {
    logic [ilb_pkg::OP_W-1:0]  op;
    logic [ilb_pkg::POS_W-1:0] pos;
    logic [ilb_pkg::VAL_W-1:0] val;
    logic                      typed;
    logic [ilb_pkg::ST_W-1:0]  st;
    logic [ilb_pkg::POS_W-1:0] at;
    logic [ilb_pkg::VAL_W-1:0] rv;
    logic [ilb_pkg::CNT_W-1:0] cnt;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // position[7:0], item_value[39:8]
  logic [1:0]  s_axis_tuser;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // placed_at[7:0], read_value[39:8], count[44:40]
  logic [1:0]  m_axis_tuser;   // status[1:0]

  logic [ilb_pkg::VAL_W-1:0] shadow_list[$];
  list_result_t              pending_results[$];
  list_result_t              seen_beat;
  list_result_t              want_beat;
  dir_row_t                  dir_tbl [DIR_N];

  int  errors = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_full = 0;
  int  n_range = 0;
  int  n_ok = 0;
  int  idle_cycles = 0;
  int  tx_gap = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  bit  long_hold_req = 1'b0;

  indexed_list_buffer #(.CAPACITY(LIST_CAP)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  // Apply one list operation to the shadow list and return the result beat
  function automatic list_result_t list_apply(input logic [ilb_pkg::OP_W-1:0] op,
                                              input logic [ilb_pkg::POS_W-1:0] pos,
                                              input logic [ilb_pkg::VAL_W-1:0] val);
    list_result_t r;
    int           at;
    int           n;
    r.status = ilb_pkg::ST_RANGE;
    r.placed = pos;
    r.value  = '0;
    case (op)
      ilb_pkg::OP_INSERT: begin
        if (shadow_list.size() >= LIST_CAP) begin
          r.status = ilb_pkg::ST_FULL;
        end else begin
          at = (int'(pos) > shadow_list.size()) ? shadow_list.size() : int'(pos);
          shadow_list.insert(at, val);
          r.status = ilb_pkg::ST_OK;
          r.placed = at[ilb_pkg::POS_W-1:0];
        end
      end
      ilb_pkg::OP_REMOVE: begin
        if (int'(pos) < shadow_list.size()) begin
          r.value = shadow_list[pos];
          shadow_list.delete(int'(pos));
          r.status = ilb_pkg::ST_OK;
        end
      end
      ilb_pkg::OP_READ: begin
        if (int'(pos) < shadow_list.size()) begin
          r.value  = shadow_list[pos];
          r.status = ilb_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    n = shadow_list.size();
    r.cnt = n[ilb_pkg::CNT_W-1:0];
    return r;
  endfunction

  // Idle length: mostly none, often short, sometimes long
  function automatic int idle_len(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ilb_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Offer one beat and hold it until taken; lower valid only if a gap follows
  task automatic send_beat(input logic [ilb_pkg::OP_W-1:0] op,
                           input logic [ilb_pkg::POS_W-1:0] pos,
                           input logic [ilb_pkg::VAL_W-1:0] val);
    repeat (tx_gap) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, pos};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_sent++;
    tx_gap = idle_len(tx_steady);
    if (tx_gap != 0) s_axis_tvalid <= 1'b0;
  endtask

  // Lower valid right after the last taken beat, unless a gap already did
  task automatic drop_valid();
    if (tx_gap == 0) begin
      s_axis_tvalid <= 1'b0;
      tx_gap = 1;
    end
  endtask

  // Receiver: random stalls, steady stretches, and one long hold on request
  initial begin
    int hold_left;
    int cyc;
    hold_left = 0;
    cyc = 0;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      cyc++;
      if (cyc % 200 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else begin
        hold_left = idle_len(rx_steady);
        if (hold_left == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          hold_left--;
        end
      end
      @(posedge clk);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_beat.status = m_axis_tuser;
      seen_beat.placed = m_axis_tdata[7:0];
      seen_beat.value  = m_axis_tdata[39:8];
      seen_beat.cnt    = m_axis_tdata[44:40];
      n_checked++;
      case (seen_beat.status)
        ilb_pkg::ST_OK:    n_ok++;
        ilb_pkg::ST_FULL:  n_full++;
        ilb_pkg::ST_RANGE: n_range++;
        default: ;
      endcase
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result beat st=%0d at=%0d val=%h cnt=%0d",
                   seen_beat.status, seen_beat.placed, seen_beat.value, seen_beat.cnt);
      end else begin
        want_beat = pending_results.pop_front();
        if (seen_beat !== want_beat) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: beat %0d exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                     n_checked, want_beat.status, want_beat.placed, want_beat.value,
                     want_beat.cnt, seen_beat.status, seen_beat.placed, seen_beat.value,
                     seen_beat.cnt);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [ilb_pkg::OP_W-1:0]  op;
    logic [ilb_pkg::POS_W-1:0] pos;
    logic [ilb_pkg::VAL_W-1:0] val;
    list_result_t              pred;
    int                        occ;
    int                        r;
    int                        k;

    // Empty-list errors, extremes, ordering, fill to full, full insert, tail ops
    dir_tbl = '{
      '{ilb_pkg::OP_READ, 8'd0, 32'h0, 1'b1, ilb_pkg::ST_RANGE, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_REMOVE, 8'd255, 32'hffff_ffff, 1'b1, ilb_pkg::ST_RANGE, 8'd255,
        32'h0, 5'd0},
      '{OP_UNUSED, 8'd7, 32'h1111_1111, 1'b1, ilb_pkg::ST_RANGE, 8'd7, 32'h0, 5'd0},
      '{ilb_pkg::OP_INSERT, 8'd255, 32'h7fff_ffff, 1'b1, ilb_pkg::ST_OK, 8'd0,
        32'h0, 5'd1},
      '{ilb_pkg::OP_INSERT, 8'd0, 32'h8000_0000, 1'b1, ilb_pkg::ST_OK, 8'd0,
        32'h0, 5'd2},
      '{ilb_pkg::OP_READ, 8'd0, 32'h0, 1'b1, ilb_pkg::ST_OK, 8'd0, 32'h8000_0000, 5'd2},
      '{ilb_pkg::OP_READ, 8'd1, 32'h0, 1'b1, ilb_pkg::ST_OK, 8'd1, 32'h7fff_ffff, 5'd2},
      '{ilb_pkg::OP_INSERT, 8'd1, 32'hffff_ffff, 1'b1, ilb_pkg::ST_OK, 8'd1,
        32'h0, 5'd3},
      '{ilb_pkg::OP_INSERT, 8'd255, 32'h0000_0000, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_INSERT, 8'd0,   32'h0000_0001, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_INSERT, 8'd2,   32'hdead_beef, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_INSERT, 8'd1,   32'h5555_5555, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_INSERT, 8'd5,   32'haaaa_aaaa, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_INSERT, 8'd200, 32'h0123_4567, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_INSERT, 8'd3,   32'h89ab_cdef, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_INSERT, 8'd128, 32'h0f0f_0f0f, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_INSERT, 8'd7,   32'hf0f0_f0f0, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_INSERT, 8'd0,   32'h8000_0001, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_INSERT, 8'd64,  32'h7fff_fffe, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_INSERT, 8'd11,  32'h3c3c_3c3c, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_INSERT, 8'd15,  32'hc3c3_c3c3, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_INSERT, 8'd9, 32'h0000_1234, 1'b1, ilb_pkg::ST_FULL, 8'd9,
        32'h0, 5'd16},
      '{ilb_pkg::OP_REMOVE, 8'd0,  32'h0, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_REMOVE, 8'd14, 32'h0, 1'b0, ilb_pkg::ST_OK, 8'd0, 32'h0, 5'd0},
      '{ilb_pkg::OP_READ, 8'd14, 32'h0, 1'b1, ilb_pkg::ST_RANGE, 8'd14, 32'h0, 5'd14}
    };

    // Hold reset with all inputs quiet
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < DIR_N; i++) begin
      pred = list_apply(dir_tbl[i].op, dir_tbl[i].pos, dir_tbl[i].val);
      if (dir_tbl[i].typed)
        pending_results.push_back({dir_tbl[i].st, dir_tbl[i].at, dir_tbl[i].rv, dir_tbl[i].cnt});
      else
        pending_results.push_back(pred);
      send_beat(dir_tbl[i].op, dir_tbl[i].pos, dir_tbl[i].val);
    end

    // Random ops, biased so the list wanders between empty and full
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 60 == 0) tx_steady = ($urandom_range(0, 2) == 0);
      if (i == 100) long_hold_req = 1'b1;
      if (i == 250) begin
        drop_valid();
        while (pending_results.size() != 0) @(posedge clk);
      end
      occ = shadow_list.size();
      r = $urandom_range(0, 99);
      if (r < 3)
        op = OP_UNUSED;
      else if (r < 3 + ((occ == LIST_CAP) ? 25 : (occ < 4) ? 55 : 40))
        op = ilb_pkg::OP_INSERT;
      else if ($urandom_range(0, 1) == 0)
        op = ilb_pkg::OP_REMOVE;
      else
        op = ilb_pkg::OP_READ;
      if ($urandom_range(0, 99) < 85)
        k = $urandom_range(0, occ);
      else
        k = $urandom_range(0, 255);
      pos = k[ilb_pkg::POS_W-1:0];
      val = pick_value();
      pending_results.push_back(list_apply(op, pos, val));
      send_beat(op, pos, val);
    end
    drop_valid();

    // Drain outstanding results, then give stray beats a chance to show
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    errors += pending_results.size();
    $display("Ran %0d ops (%0d directed), checked %0d result beats", n_sent, DIR_N, n_checked);
    $display("Outcomes: %0d ok, %0d out of range, %0d list full, %0d mismatches",
             n_ok, n_range, n_full, errors);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ilb_pkg.sv
rtl/ilb_ctrl.sv
rtl/ilb_dp.sv
rtl/indexed_list_buffer.sv
rtl/ilb_checker.sv
tb/indexed_list_buffer_tb.sv
